// ===== hdl/tad_pkg.sv =====
// ----------------------------------------------------------------------------
// tad_pkg
// Shared widths, constants and types for the thermistor temperature pipeline.
// ----------------------------------------------------------------------------
package tad_pkg;

  // ADC and table
  localparam int ADC_W          = 10;
  localparam int ADC_FULL_SCALE = 1023;
  localparam int TBL_AW         = ADC_W;
  localparam int TBL_DEPTH      = 1 << TBL_AW;

  // configuration port
  localparam int IDX_W  = 3;
  localparam int CFG_DW = 20;
  localparam int OHM_W  = 20;
  localparam int T0_W   = 15;
  localparam int BETA_W = 14;

  localparam logic [OHM_W-1:0]         SERIES_RST  = OHM_W'(10000);
  localparam logic [OHM_W-1:0]         NOMINAL_RST = OHM_W'(10000);
  localparam logic signed [T0_W-1:0]   T0_RST      = T0_W'(2500);
  localparam logic [BETA_W-1:0]        BETA_RST    = BETA_W'(3950);

  typedef enum logic [IDX_W-1:0] {
    REG_SERIES  = 3'd0,
    REG_NOMINAL = 3'd1,
    REG_T0      = 3'd2,
    REG_BETA    = 3'd3,
    REG_SUPPLY  = 3'd4
  } reg_idx_t;

  // log2: exponent plus 28-bit fraction
  localparam int LOG_FRAC  = 28;
  localparam int LOG_EW    = 5;
  localparam int LOG_W     = LOG_EW + LOG_FRAC;
  localparam int MANT_W    = 31;
  localparam int ITER_W    = $clog2(LOG_FRAC);
  localparam int ITER_LAST = LOG_FRAC - 1;

  // natural log
  localparam int SUM_W  = LOG_W + 1;
  localparam int LN2_W  = 30;
  localparam logic [LN2_W-1:0] LN2_Q30 = LN2_W'(744261118);
  localparam int LN_SH  = 34;
  localparam int LN_W   = SUM_W + LN2_W - LN_SH;

  // beta equation
  localparam int KELVIN_CENTI = 27315;
  localparam int T0K_W  = 16;
  localparam int BH_W   = 21;
  localparam int BT_W   = BETA_W + T0K_W;
  localparam int NB_W   = 37;
  localparam int NUM_SH = 24;
  localparam int PROD_W = LN_W + T0K_W;
  localparam int DEN_W  = 48;
  localparam int DV_W   = DEN_W - 1;
  localparam int NP_W   = NB_W + NUM_SH + 1;
  localparam int QW     = 17;
  localparam int CMP_W  = DV_W + QW;

  // output conversion
  localparam int CC_W     = QW + 1;
  localparam int X_W      = 20;
  localparam int R_W      = 20;
  localparam logic [R_W-1:0] RECIP5 = R_W'(838861);
  localparam int RECIP_SH = 22;
  localparam int FQ_W     = X_W + R_W - RECIP_SH;
  localparam int FC_W     = 20;
  localparam int F_OFFSET = 3200;
  localparam int OUT_W    = 16;
  localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic               ready;
    logic [LOG_W-1:0]   log_series;
    logic [LOG_W-1:0]   log_nominal;
    logic [T0K_W-1:0]   t0c;
    logic [BH_W-1:0]    beta100;
    logic [NB_W-1:0]    numb;
  } cal_t;

  typedef struct packed {
    logic               we;
    logic [TBL_AW-1:0]  addr;
    logic [LOG_W-1:0]   data;
  } tbl_wr_t;

  typedef struct packed {
    logic               fault;
    logic               neg;
    logic [LN_W-1:0]    lnmag;
  } ln_t;

  typedef struct packed {
    logic               fault;
    logic               satf;
    logic [QW-1:0]      tck;
  } res_t;

endpackage

// ===== hdl/thermistor_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// NTC thermistor divider reading to Celsius and Fahrenheit (beta equation).
// ----------------------------------------------------------------------------
//  channel  direction  signals                                   beat
//  input    in         in_valid/in_ready, adc_code               one ADC code
//  output   out        out_valid/out_ready, temp_centi_c,        one reading
//                      temp_centi_f, fault
//  config   in         cfg_valid/cfg_ready, cfg_index, cfg_data  one register
//
// Rate: one beat per clock in steady state, with out_ready high and no
//   refresh running; the path from input to output has 4 log/ln stages,
//   4 equation stages, 17 divider stages, one per quotient bit, and 3
//   conversion stages including the output register.
// Reset: the log2 table for codes 1..1022 is filled by the shared squaring
//   unit, then the resistor logs, all with in_ready low. Each config write
//   then holds in_ready low while both resistor logs are redone.
// Stalls: every stage has its own valid bit and loads when it is empty or
//   the stage after it moves, so bubbles close up and nothing is dropped.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tad_pkg::ADC_W-1:0]        adc_code,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tad_pkg::OUT_W-1:0] temp_centi_c,
  output logic signed [tad_pkg::OUT_W-1:0] temp_centi_f,
  output logic                             fault,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tad_pkg::IDX_W-1:0]        cfg_index,
  input  logic [tad_pkg::CFG_DW-1:0]       cfg_data
);
  import tad_pkg::*;

  cal_t    cal;
  tbl_wr_t tbl_wr;
  ln_t     ln;
  res_t    res;
  logic    ln_in_ready;
  logic    ln_valid, ln_ready;
  logic    res_valid, res_ready;

  // register writes always land; the sequencer restarts as needed
  assign cfg_ready = 1'b1;

  // inputs wait until the table and resistor logs are current
  assign in_ready = ln_in_ready && cal.ready;

  tad_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal),
    .tbl_wr    (tbl_wr)
  );

  tad_ln u_ln (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid && cal.ready),
    .in_ready  (ln_in_ready),
    .adc_code  (adc_code),
    .cal       (cal),
    .tbl_wr    (tbl_wr),
    .out_valid (ln_valid),
    .out_ready (ln_ready),
    .out       (ln)
  );

  tad_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ln_valid),
    .in_ready  (ln_ready),
    .in        (ln),
    .cal       (cal),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out       (res)
  );

  tad_out u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (res_valid),
    .in_ready     (res_ready),
    .in           (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .temp_centi_c (temp_centi_c),
    .temp_centi_f (temp_centi_f),
    .fault        (fault)
  );

  // a faulted reading carries zero temperatures
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> (temp_centi_c == '0) && (temp_centi_f == '0))
    else $error("fault beat with nonzero temperature");

  // no code is taken while the table or logs are being rebuilt
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    !cal.ready |-> !in_ready)
    else $error("input taken while calibration busy");

  // table writes only happen during the post-reset fill
  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.we |-> !cal.ready)
    else $error("table write while ready");

  // a config write while ready starts a log refresh
  a_cfg_refresh: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cal.ready |=> !cal.ready)
    else $error("config write did not start refresh");

endmodule

// ===== hdl/tad_log.sv =====
// ----------------------------------------------------------------------------
// tad_log
// Iterative log2: exponent from leading one, 28 fraction bits by squaring.
// ----------------------------------------------------------------------------
module tad_log (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tad_pkg::OHM_W-1:0]  x,
  output logic                       run,
  output logic                       done,
  output logic [tad_pkg::LOG_W-1:0]  res
);
  import tad_pkg::*;

  logic [LOG_EW-1:0]   e;
  logic [LOG_EW-1:0]   e0;
  logic [LOG_EW-1:0]   sh;
  logic [MANT_W-1:0]   m;
  logic [MANT_W-1:0]   m0;
  logic [LOG_FRAC-1:0] frac;
  logic [ITER_W-1:0]   cnt;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     t;

  always_comb begin
    e0 = '0;
    for (int i = 0; i < OHM_W; i++) begin
      if (x[i]) begin
        e0 = LOG_EW'(i);
      end
    end
  end

  assign sh  = LOG_EW'(MANT_W - 1) - e0;
  assign m0  = MANT_W'(x) << sh;
  assign sq  = m * m;
  assign t   = sq[2*MANT_W-1:MANT_W-1];
  assign res = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == ITER_W'(ITER_LAST));
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == ITER_W'(ITER_LAST))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      e    <= e0;
      m    <= m0;
      frac <= '0;
      cnt  <= '0;
    end else if (run) begin
      cnt  <= cnt + ITER_W'(1);
      m    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
      frac <= {frac[LOG_FRAC-2:0], t[MANT_W]};
    end
  end

endmodule

// ===== hdl/tad_cfg.sv =====
// ----------------------------------------------------------------------------
// tad_cfg
// Config registers, derived constants, and the log sequencer that fills the
// code table after reset and refreshes the resistor logs after each write.
// ----------------------------------------------------------------------------
module tad_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [tad_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tad_pkg::CFG_DW-1:0] cfg_data,
  output tad_pkg::cal_t              cal,
  output tad_pkg::tbl_wr_t           tbl_wr
);
  import tad_pkg::*;

  typedef enum logic [1:0] {ST_FILL, ST_SER, ST_NOM, ST_IDLE} st_t;

  st_t                      st;
  logic                     redo;
  logic [TBL_AW-1:0]        fill_addr;
  logic [OHM_W-1:0]         series_ohms;
  logic [OHM_W-1:0]         nominal_ohms;
  logic signed [T0_W-1:0]   t0_centi;
  logic [BETA_W-1:0]        beta;
  logic [LOG_W-1:0]         log_series;
  logic [LOG_W-1:0]         log_nominal;
  logic [T0K_W-1:0]         t0c;
  logic [BH_W-1:0]          beta100;
  logic [BT_W-1:0]          bt;
  logic [NB_W-1:0]          numb;
  logic [T0_W+1:0]          t0_sum;
  logic                     lg_start;
  logic                     lg_run;
  logic                     lg_done;
  logic [OHM_W-1:0]         lg_x;
  logic [LOG_W-1:0]         lg_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_ohms  <= SERIES_RST;
      nominal_ohms <= NOMINAL_RST;
      t0_centi     <= T0_RST;
      beta         <= BETA_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SERIES:  series_ohms  <= cfg_data[OHM_W-1:0];
        REG_NOMINAL: nominal_ohms <= cfg_data[OHM_W-1:0];
        REG_T0:      t0_centi     <= cfg_data[T0_W-1:0];
        REG_BETA:    beta         <= cfg_data[BETA_W-1:0];
        REG_SUPPLY:  ;  // supply cancels out of the divider ratio
        default:     ;
      endcase
    end
  end

  // T0 in centikelvin is always positive and below 2^16
  assign t0_sum = {{2{t0_centi[T0_W-1]}}, t0_centi} + (T0_W+2)'(KELVIN_CENTI);

  always_ff @(posedge clk) begin
    t0c     <= t0_sum[T0K_W-1:0];
    beta100 <= BH_W'(beta) * BH_W'(100);
    bt      <= BT_W'(beta) * BT_W'(t0c);
    numb    <= NB_W'(bt) * NB_W'(100);
  end

  always_comb begin
    case (st)
      ST_FILL: lg_x = OHM_W'(fill_addr);
      ST_SER:  lg_x = series_ohms;
      ST_NOM:  lg_x = nominal_ohms;
      default: lg_x = series_ohms;
    endcase
  end

  assign lg_start = (st != ST_IDLE) && !lg_run && !lg_done;

  tad_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (lg_start),
    .x     (lg_x),
    .run   (lg_run),
    .done  (lg_done),
    .res   (lg_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_FILL;
      fill_addr <= TBL_AW'(1);
      redo      <= 1'b0;
    end else begin
      case (st)
        ST_FILL: begin
          if (cfg_valid) redo <= 1'b1;
          if (lg_done) begin
            if (fill_addr == TBL_AW'(ADC_FULL_SCALE - 1)) begin
              st <= ST_SER;
            end else begin
              fill_addr <= fill_addr + TBL_AW'(1);
            end
          end
        end
        ST_SER: begin
          if (cfg_valid) redo <= 1'b1;
          if (lg_done) begin
            log_series <= lg_res;
            st         <= ST_NOM;
          end
        end
        ST_NOM: begin
          if (lg_done) begin
            log_nominal <= lg_res;
            st          <= (redo || cfg_valid) ? ST_SER : ST_IDLE;
            redo        <= 1'b0;
          end else if (cfg_valid) begin
            redo <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (cfg_valid) st <= ST_SER;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign tbl_wr.we   = lg_done && (st == ST_FILL);
  assign tbl_wr.addr = fill_addr;
  assign tbl_wr.data = lg_res;

  assign cal.ready       = (st == ST_IDLE);
  assign cal.log_series  = log_series;
  assign cal.log_nominal = log_nominal;
  assign cal.t0c         = t0c;
  assign cal.beta100     = beta100;
  assign cal.numb        = numb;

endmodule

// ===== hdl/tad_ln.sv =====
// ----------------------------------------------------------------------------
// tad_ln
// Table lookup of log2 code terms, log sums, magnitude and scale to ln Q24.
// ----------------------------------------------------------------------------
module tad_ln (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tad_pkg::ADC_W-1:0] adc_code,
  input  tad_pkg::cal_t             cal,
  input  tad_pkg::tbl_wr_t          tbl_wr,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tad_pkg::ln_t              out
);
  import tad_pkg::*;

  logic [LOG_W-1:0] tbl [TBL_DEPTH];

  logic                    v1, v2, v3, v4;
  logic                    en1, en2, en3, en4;
  logic                    fault1, fault2, fault3, fault4;
  logic [LOG_W-1:0]        lv1, lf1;
  logic [SUM_W-1:0]        a2, b2;
  logic                    neg3, neg4;
  logic [SUM_W-1:0]        mag3;
  logic [LN_W-1:0]         lnmag4;
  logic [TBL_AW-1:0]       cmp_addr;
  logic [SUM_W+LN2_W-1:0]  lnp;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign cmp_addr = TBL_AW'(ADC_FULL_SCALE) - adc_code;
  assign lnp      = SUM_W'(mag3) * LN2_Q30;

  always_ff @(posedge clk) begin
    if (tbl_wr.we) tbl[tbl_wr.addr] <= tbl_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      fault1 <= (adc_code == '0) || (adc_code >= ADC_W'(ADC_FULL_SCALE));
      lv1    <= tbl[adc_code];
      lf1    <= tbl[cmp_addr];
    end
    if (en2) begin
      fault2 <= fault1;
      a2     <= SUM_W'(cal.log_series) + SUM_W'(lf1);
      b2     <= SUM_W'(lv1) + SUM_W'(cal.log_nominal);
    end
    if (en3) begin
      fault3 <= fault2;
      neg3   <= a2 < b2;
      mag3   <= (a2 < b2) ? (b2 - a2) : (a2 - b2);
    end
    if (en4) begin
      fault4 <= fault3;
      neg4   <= neg3;
      lnmag4 <= lnp[SUM_W+LN2_W-1:LN_SH];
    end
  end

  assign out_valid = v4;
  assign out.fault = fault4;
  assign out.neg   = neg4;
  assign out.lnmag = lnmag4;

endmodule

// ===== hdl/tad_div.sv =====
// ----------------------------------------------------------------------------
// tad_div
// Beta-equation denominator and numerator, then a restoring divider with one
// quotient bit per stage giving T in centikelvin, rounded half up.
// ----------------------------------------------------------------------------
module tad_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tad_pkg::ln_t  in,
  input  tad_pkg::cal_t cal,
  output logic          out_valid,
  input  logic          out_ready,
  output tad_pkg::res_t out
);
  import tad_pkg::*;

  typedef struct packed {
    logic             fault;
    logic             satf;
    logic [NP_W-1:0]  rem;
    logic [DV_W-1:0]  dpos;
    logic [QW-1:0]    q;
  } dv_t;

  logic                     v1, v2, v3;
  logic                     en1, en2, en3;
  logic                     fault1, fault2, fault3;
  logic                     neg1;
  logic [PROD_W-1:0]        prod1;
  logic signed [DEN_W-1:0]  den2;
  logic signed [DEN_W-1:0]  bsh;
  logic signed [DEN_W-1:0]  pext;
  logic                     nonpos3;
  logic [NP_W-1:0]          np3;
  logic [DV_W-1:0]          dpos3;

  logic vld [QW+1];
  logic en  [QW+1];
  dv_t  sd  [QW+1];

  assign en[QW] = !vld[QW] || out_ready;
  assign en3    = !v3 || en[0];
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign in_ready = en1;

  assign bsh  = DEN_W'({cal.beta100, {NUM_SH{1'b0}}});
  assign pext = DEN_W'(prod1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      fault1 <= in.fault;
      neg1   <= in.neg;
      prod1  <= PROD_W'(in.lnmag) * PROD_W'(cal.t0c);
    end
    if (en2) begin
      fault2 <= fault1;
      den2   <= neg1 ? (bsh - pext) : (bsh + pext);
    end
    if (en3) begin
      fault3  <= fault2;
      nonpos3 <= den2[DEN_W-1] || (den2 == '0);
      // numerator plus half the divisor gives round half up
      np3     <= NP_W'({cal.numb, {NUM_SH{1'b0}}}) + NP_W'(den2[DEN_W-2:1]);
      dpos3   <= den2[DEN_W-2:0];
    end
  end

  // head stage: quotient overflow check, T then lies far above any output
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sd[0].fault <= fault3;
      sd[0].satf  <= nonpos3 || (CMP_W'(np3) >= {dpos3, {QW{1'b0}}});
      sd[0].rem   <= np3;
      sd[0].dpos  <= dpos3;
      sd[0].q     <= '0;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_bit
    localparam int K = QW - j;
    logic [CMP_W-1:0] dsh;
    logic             ge;

    assign en[j-1] = !vld[j-1] || en[j];
    assign dsh     = CMP_W'(sd[j-1].dpos) << K;
    assign ge      = CMP_W'(sd[j-1].rem) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en[j]) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        sd[j].fault <= sd[j-1].fault;
        sd[j].satf  <= sd[j-1].satf;
        sd[j].dpos  <= sd[j-1].dpos;
        sd[j].rem   <= ge ? (sd[j-1].rem - dsh[NP_W-1:0]) : sd[j-1].rem;
        sd[j].q     <= sd[j-1].q | (QW'(ge) << K);
      end
    end
  end

  assign out_valid = vld[QW];
  assign out.fault = sd[QW].fault;
  assign out.satf  = sd[QW].satf;
  assign out.tck   = sd[QW].q;

endmodule

// ===== hdl/tad_out.sv =====
// ----------------------------------------------------------------------------
// tad_out
// Centikelvin to Celsius and Fahrenheit, saturation, and the output register.
// ----------------------------------------------------------------------------
module tad_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tad_pkg::res_t                    in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tad_pkg::OUT_W-1:0] temp_centi_c,
  output logic signed [tad_pkg::OUT_W-1:0] temp_centi_f,
  output logic                             fault
);
  import tad_pkg::*;

  logic                     v1, v2;
  logic                     en1, en2, en3;
  logic [CC_W-1:0]          cc;
  logic [CC_W-1:0]          ccn;
  logic                     ccneg;
  logic [CC_W-2:0]          absc;
  logic                     fault1, fault2;
  logic                     satf1, satf2;
  logic                     neg1, neg2;
  logic [X_W-1:0]           x1;
  logic signed [OUT_W-1:0]  c1, c2;
  logic [X_W+R_W-1:0]       p2;
  logic [FQ_W-1:0]          fq;
  logic signed [FC_W-1:0]   fc;
  logic signed [OUT_W-1:0]  f16;

  assign en3 = !out_valid || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  // T is never negative, so Celsius stays above the low rail
  assign cc    = CC_W'(in.tck) - CC_W'(KELVIN_CENTI);
  assign ccn   = -cc;
  assign ccneg = cc[CC_W-1];
  assign absc  = ccneg ? ccn[CC_W-2:0] : cc[CC_W-2:0];

  // (|C|*9 + 2) / 5 by reciprocal multiply
  assign fq = p2[X_W+R_W-1:RECIP_SH];
  assign fc = neg2 ? (FC_W'(F_OFFSET) - FC_W'(fq)) : (FC_W'(F_OFFSET) + FC_W'(fq));

  always_comb begin
    if (fc > FC_W'(SAT_MAX)) begin
      f16 = SAT_MAX;
    end else if (fc < FC_W'(SAT_MIN)) begin
      f16 = SAT_MIN;
    end else begin
      f16 = fc[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      fault1 <= in.fault;
      satf1  <= in.satf;
      neg1   <= ccneg;
      x1     <= X_W'(absc) * X_W'(9) + X_W'(2);
      if (!ccneg && (cc[CC_W-2:0] > (CC_W-1)'(SAT_MAX))) begin
        c1 <= SAT_MAX;
      end else begin
        c1 <= cc[OUT_W-1:0];
      end
    end
    if (en2) begin
      fault2 <= fault1;
      satf2  <= satf1;
      neg2   <= neg1;
      c2     <= c1;
      p2     <= (X_W+R_W)'(x1) * (X_W+R_W)'(RECIP5);
    end
    if (en3) begin
      fault <= fault2;
      if (fault2) begin
        temp_centi_c <= '0;
        temp_centi_f <= '0;
      end else if (satf2) begin
        temp_centi_c <= SAT_MAX;
        temp_centi_f <= SAT_MAX;
      end else begin
        temp_centi_c <= c2;
        temp_centi_f <= f16;
      end
    end
  end

endmodule
